// File: src/sd_spi_command_engine_core_macros.svh
// Assertion helpers for the SD SPI command engine.
`ifndef SD_SPI_COMMAND_ENGINE_CORE_MACROS_SVH
`define SD_SPI_COMMAND_ENGINE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SDSPI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SDSPI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SDSPI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SDSPI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/sdspi_pkg.sv
package sdspi_pkg;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  cmd_number;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_byte;
  } sdspi_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_active;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       done_res;
    logic       failed;
    logic [7:0] response;
  } sdspi_res_t;

  // Classified item handed from the front end to the engine.
  typedef struct packed {
    sdspi_item_t item;
    logic        scale;   // CMD17/18/24/25 start, argument scaled to bytes
  } sdspi_job_t;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_XFER  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  localparam logic [0:0] CFG_ADDR_BLOCK = 1'd0;
  localparam logic [0:0] CFG_TIMEOUT    = 1'd1;

  localparam logic [7:0] CMD_FLAG   = 8'h40;
  localparam logic [7:0] CRC_CMD0   = 8'h95;
  localparam logic [7:0] CRC_CMD8   = 8'h87;
  localparam logic [7:0] TOKEN_DATA = 8'hFE;
  localparam logic [7:0] DRESP_MASK = 8'h1F;
  localparam logic [7:0] DRESP_OK   = 8'h05;
  localparam logic [7:0] IDLE_BYTE  = 8'hFF;

  function automatic logic is_read_cmd(input logic [5:0] c);
    return (c == 6'd9) || (c == 6'd10) || (c == 6'd17) || (c == 6'd18);
  endfunction

  function automatic logic is_write_cmd(input logic [5:0] c);
    return (c == 6'd24) || (c == 6'd25);
  endfunction

endpackage

// File: src/sd_spi_command_engine_core.sv
// SD card SPI-mode host command engine. Each input item is a start request, a finished
// byte exchange, a timer tick or a busy flush; each gives at most one result naming the
// next exchange, a data byte or transaction completion. Items go through a two-entry
// queue into the engine, which handles one item per cycle while its result register is
// free or being popped; an accepted item is written into the queue, and the result
// register loads when the engine takes the item from the queue and drives the outputs.
`include "sd_spi_command_engine_core_macros.svh"
module sd_spi_command_engine_core
  import sdspi_pkg::*;
#(
  parameter int PHYS_BLOCK_SIZE = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_op,
  input  logic [5:0]  in_cmd_number,
  input  logic [31:0] in_argument,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_wr_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_cs_active,
  output logic        out_rd_valid,
  output logic [7:0]  out_rd_byte,
  output logic        out_done_res,
  output logic        out_failed,
  output logic [7:0]  out_response
);

  sdspi_item_t it;
  sdspi_job_t  job;
  sdspi_res_t  res;
  logic        job_valid, job_pop, res_valid, res_pop, eng_idle;

  assign it.op = in_op;
  assign it.cmd_number = in_cmd_number;
  assign it.argument = in_argument;
  assign it.rx_byte = in_rx_byte;
  assign it.wr_byte = in_wr_byte;

  sdspi_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item(it),
    .job_valid, .job_pop, .job
  );

  sdspi_engine #(.PHYS_BLOCK_SIZE(PHYS_BLOCK_SIZE)) u_engine (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .job_valid, .job_pop, .job, .res_valid, .res_pop, .res, .eng_idle
  );

  assign out_empty = !res_valid;
  assign res_pop = out_pop && res_valid;
  assign out_tx_valid = res.tx_valid;
  assign out_tx_byte = res.tx_byte;
  assign out_cs_active = res.cs_active;
  assign out_rd_valid = res.rd_valid;
  assign out_rd_byte = res.rd_byte;
  assign out_done_res = res.done_res;
  assign out_failed = res.failed;
  assign out_response = res.response;

  `SDSPI_ASSERT_NXT(a_hold_result, clk, rst_n, res_valid && !out_pop, res_valid && $stable(res))
  `SDSPI_ASSERT_IMP(a_done_idle, clk, rst_n, res_valid && res.done_res && !job_pop, eng_idle)
  `SDSPI_ASSERT_IMP(a_pop_needs_job, clk, rst_n, job_pop, job_valid)

endmodule

// File: src/sdspi_front.sv
module sdspi_front
  import sdspi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  sdspi_item_t in_item,
  output logic        job_valid,
  input  logic        job_pop,
  output sdspi_job_t  job
);

  localparam int Depth = 2;

  sdspi_job_t    q_r [Depth];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push_ok;
  sdspi_job_t    jin;

  assign in_full   = (cnt_r == 2'(Depth));
  assign push_ok   = in_push && !in_full;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];

  always_comb begin
    jin.item  = in_item;
    jin.scale = (in_item.op == OP_START) &&
                (in_item.cmd_number != 6'd9) && (in_item.cmd_number != 6'd10) &&
                (is_read_cmd(in_item.cmd_number) || is_write_cmd(in_item.cmd_number));
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= jin;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (job_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(job_pop);
    end
  end

endmodule

// File: src/sdspi_engine.sv
module sdspi_engine
  import sdspi_pkg::*;
#(
  parameter int PHYS_BLOCK_SIZE = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       job_valid,
  output logic       job_pop,
  input  sdspi_job_t job,
  output logic       res_valid,
  input  logic       res_pop,
  output sdspi_res_t res,
  output logic       eng_idle
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_PRE, PH_BUSYW, PH_CMDB, PH_RESP, PH_R1B, PH_EXTRA,
    PH_W_GAP, PH_W_TOKEN, PH_W_DATA, PH_W_CRC, PH_W_DRESP, PH_W_GAP2,
    PH_W_BUSY, PH_R_TOKEN, PH_R_DATA, PH_R_CRC, PH_EPI, PH_EPI_FAIL,
    PH_F_PRE, PH_F_BUSY
  } phase_t;

  phase_t      ph_r, ph_nxt;
  logic        abb_r;
  logic [7:0]  tlim_r;
  logic [15:0] blen_r, blen_nxt, sblen_r, sblen_nxt, bc_r, bc_nxt;
  logic [5:0]  cmd_r, cmd_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic [7:0]  tick_r, tick_nxt, r1_r, r1_nxt;
  logic        busy_r, busy_nxt, app_r, app_nxt;
  sdspi_res_t  o, res_r;
  logic        emit, rv_r;
  logic [5:0]  ec;
  logic [15:0] bc_inc, bc_dec;
  logic [7:0]  rx;
  logic [31:0] a_sel;

  // One result register; the job queue drains only when it is free or leaving.
  assign job_pop   = job_valid && (!rv_r || res_pop);
  assign res_valid = rv_r;
  assign res       = res_r;
  assign eng_idle  = (ph_r == PH_IDLE);

  assign rx     = job.item.rx_byte;
  assign ec     = app_r ? 6'd55 : cmd_r;
  assign bc_inc = bc_r + 16'd1;
  assign bc_dec = bc_r - 16'd1;
  assign a_sel  = app_r ? 32'd0 : arg_r;

  always_comb begin
    ph_nxt = ph_r; blen_nxt = blen_r; sblen_nxt = sblen_r; bc_nxt = bc_r;
    cmd_nxt = cmd_r; arg_nxt = arg_r; tick_nxt = tick_r; r1_nxt = r1_r;
    busy_nxt = busy_r; app_nxt = app_r;
    o = '0; emit = 1'b0;
    if (job_pop) begin
      unique case (job.item.op)
        OP_TICK: begin
          if (tick_r != 8'hFF) tick_nxt = tick_r + 8'd1;
        end
        OP_START: begin
          if (ph_r == PH_IDLE) begin
            emit = 1'b1;
            cmd_nxt = job.item.cmd_number;
            sblen_nxt = blen_r;
            arg_nxt = (job.scale && !abb_r) ?
                      32'(job.item.argument * 32'(PHYS_BLOCK_SIZE)) : job.item.argument;
            app_nxt = (job.item.cmd_number == 6'd41);
            r1_nxt = 8'd0;
            ph_nxt = PH_PRE;
            o.tx_valid = 1'b1; o.tx_byte = IDLE_BYTE;
          end
        end
        OP_FLUSH: begin
          if (ph_r == PH_IDLE) begin
            emit = 1'b1;
            if (busy_r) begin
              busy_nxt = 1'b0; ph_nxt = PH_F_PRE;
              o.tx_valid = 1'b1; o.tx_byte = IDLE_BYTE;
            end else o.done_res = 1'b1;
          end
        end
        default: begin
          if (ph_r != PH_IDLE) begin
            logic do_op, do_after, do_epi, epi_fail, do_blk, blk_rd, do_send;
            logic [7:0] sb;
            do_op = 1'b0; do_after = 1'b0; do_epi = 1'b0; epi_fail = 1'b0;
            do_blk = 1'b0; blk_rd = 1'b0; do_send = 1'b1; sb = IDLE_BYTE;
            emit = 1'b1;
            case (ph_r)
              PH_PRE: begin
                if (busy_r) begin busy_nxt = 1'b0; ph_nxt = PH_BUSYW; end
                else do_op = 1'b1;
              end
              PH_BUSYW: if (rx != 8'd0) do_op = 1'b1;
              PH_CMDB: begin
                bc_nxt = bc_inc;
                if (bc_inc <= 16'd4) begin
                  case (bc_inc[2:0])
                    3'd1:    sb = a_sel[31:24];
                    3'd2:    sb = a_sel[23:16];
                    3'd3:    sb = a_sel[15:8];
                    default: sb = a_sel[7:0];
                  endcase
                end else if (bc_inc == 16'd5) begin
                  sb = (ec == 6'd0) ? CRC_CMD0 : ((ec == 6'd8) ? CRC_CMD8 : IDLE_BYTE);
                end else begin
                  ph_nxt = PH_RESP; tick_nxt = 8'd0;
                end
              end
              PH_RESP: begin
                if (rx[7]) begin
                  if (tick_r > tlim_r) begin r1_nxt = rx; do_epi = 1'b1; end
                end else begin
                  r1_nxt = rx;
                  if (app_r) do_epi = 1'b1;
                  else if (cmd_r == 6'd13) begin
                    o.rd_valid = 1'b1; o.rd_byte = rx; r1_nxt = 8'd0;
                    ph_nxt = PH_EXTRA; bc_nxt = 16'd1;
                  end else if (cmd_r == 6'd28 || cmd_r == 6'd29 ||
                               cmd_r == 6'd38 || cmd_r == 6'd42) ph_nxt = PH_R1B;
                  else if (cmd_r == 6'd58 || cmd_r == 6'd8) begin
                    ph_nxt = PH_EXTRA; bc_nxt = 16'd4;
                  end else do_after = 1'b1;
                end
              end
              PH_R1B: if (rx != 8'd0) do_after = 1'b1;
              PH_EXTRA: begin
                o.rd_valid = 1'b1; o.rd_byte = rx; bc_nxt = bc_dec;
                if (bc_dec == 16'd0) do_after = 1'b1;
              end
              PH_W_GAP: begin ph_nxt = PH_W_TOKEN; sb = TOKEN_DATA; end
              PH_W_TOKEN: do_blk = 1'b1;
              PH_W_DATA: begin
                bc_nxt = bc_dec;
                if (bc_dec != 16'd0) sb = job.item.wr_byte;
                else begin ph_nxt = PH_W_CRC; bc_nxt = 16'd2; end
              end
              PH_W_CRC: begin
                bc_nxt = bc_dec;
                if (bc_dec == 16'd0) ph_nxt = PH_W_DRESP;
              end
              PH_W_DRESP: begin
                if ((rx & DRESP_MASK) != DRESP_OK) begin do_epi = 1'b1; epi_fail = 1'b1; end
                else ph_nxt = PH_W_GAP2;
              end
              PH_W_GAP2: ph_nxt = PH_W_BUSY;
              PH_W_BUSY: begin
                if (rx == 8'd0) busy_nxt = 1'b1;
                do_epi = 1'b1;
              end
              PH_R_TOKEN: begin
                if (rx == TOKEN_DATA) begin do_blk = 1'b1; blk_rd = 1'b1; end
                else if (rx != IDLE_BYTE || tick_r >= tlim_r) begin
                  do_epi = 1'b1; epi_fail = 1'b1;
                end
              end
              PH_R_DATA: begin
                o.rd_valid = 1'b1; o.rd_byte = rx; bc_nxt = bc_dec;
                if (bc_dec == 16'd0) begin ph_nxt = PH_R_CRC; bc_nxt = 16'd2; end
              end
              PH_R_CRC: begin
                bc_nxt = bc_dec;
                if (bc_dec == 16'd0) do_epi = 1'b1;
              end
              PH_EPI, PH_EPI_FAIL: begin
                if (app_r) begin
                  app_nxt = 1'b0; ph_nxt = PH_PRE;
                  o.tx_valid = 1'b1; o.tx_byte = IDLE_BYTE;
                end else begin
                  if (cmd_r == 6'd9 || cmd_r == 6'd10) blen_nxt = sblen_r;
                  o.done_res = 1'b1; o.failed = (ph_r == PH_EPI_FAIL);
                  o.response = r1_r; ph_nxt = PH_IDLE;
                end
                do_send = 1'b0;
              end
              PH_F_PRE: ph_nxt = PH_F_BUSY;
              PH_F_BUSY: if (rx != 8'd0) begin r1_nxt = 8'd0; do_epi = 1'b1; end
              default: do_send = 1'b0;
            endcase
            if (do_after) begin
              if (!app_r && is_read_cmd(cmd_r)) begin
                ph_nxt = PH_R_TOKEN; tick_nxt = 8'd0;
              end else if (!app_r && is_write_cmd(cmd_r)) ph_nxt = PH_W_GAP;
              else do_epi = 1'b1;
            end
            if (do_blk) begin
              if (blen_r == 16'd0) begin
                ph_nxt = blk_rd ? PH_R_CRC : PH_W_CRC; bc_nxt = 16'd2;
              end else begin
                ph_nxt = blk_rd ? PH_R_DATA : PH_W_DATA; bc_nxt = blen_r;
                if (!blk_rd) sb = job.item.wr_byte;
              end
            end
            if (do_op) begin
              if (!app_r) begin
                if (cmd_r == 6'd16) blen_nxt = arg_r[15:0];
                else if (cmd_r == 6'd9 || cmd_r == 6'd10) blen_nxt = 16'd16;
              end
              ph_nxt = PH_CMDB; bc_nxt = 16'd0;
              sb = {2'b00, ec} | CMD_FLAG;
            end
            if (do_send) begin
              o.tx_valid = 1'b1; o.tx_byte = sb; o.cs_active = 1'b1;
            end
            if (do_epi) begin
              ph_nxt = epi_fail ? PH_EPI_FAIL : PH_EPI;
              o.tx_valid = 1'b1; o.tx_byte = IDLE_BYTE; o.cs_active = 1'b0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop && emit) res_r <= o;
    if (!rst_n) begin
      ph_r <= PH_IDLE; abb_r <= 1'b0; tlim_r <= 8'd128;
      blen_r <= 16'd512; sblen_r <= 16'd512; bc_r <= '0; cmd_r <= '0;
      arg_r <= '0; tick_r <= '0; r1_r <= '0; busy_r <= 1'b0; app_r <= 1'b0;
      rv_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; blen_r <= blen_nxt; sblen_r <= sblen_nxt; bc_r <= bc_nxt;
      cmd_r <= cmd_nxt; arg_r <= arg_nxt; tick_r <= tick_nxt; r1_r <= r1_nxt;
      busy_r <= busy_nxt; app_r <= app_nxt;
      if (job_pop) rv_r <= emit;
      else if (res_pop) rv_r <= 1'b0;
      if (cfg_we && cfg_index == CFG_ADDR_BLOCK) abb_r <= cfg_data[0];
      if (cfg_we && cfg_index == CFG_TIMEOUT) tlim_r <= cfg_data;
    end
  end

endmodule
